FILE: hw/rtl/crc_generate_and_check_core_defines.svh
// assertion macros for the crc generate and check core
// expects clk and arst_n in the scope of the module that uses them
`ifndef CRC_GENERATE_AND_CHECK_CORE_DEFINES_SVH
`define CRC_GENERATE_AND_CHECK_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CRC_GC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define CRC_GC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/crc_gc_pkg.sv
// shared types and constants for the crc generate and check core
// no dependencies
`default_nettype none

package crc_gc_pkg;

	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 32;
	localparam int InfoLenW  = 16;
	localparam int CrcWidthW = 6;
	localparam int GenW      = 32;
	localparam int BitPosW   = 17;

	// configuration register map
	typedef enum logic [CfgIdxW-1:0] {
		REG_MODE      = 2'd0,
		REG_INFO_LEN  = 2'd1,
		REG_CRC_WIDTH = 2'd2,
		REG_GENERATOR = 2'd3
	} cfg_reg_t;

	// operating modes
	localparam logic MODE_GENERATE = 1'b0;
	localparam logic MODE_CHECK    = 1'b1;

	// register reset values
	localparam logic [InfoLenW-1:0]  InfoLenRst  = 16'd64;
	localparam logic [CrcWidthW-1:0] CrcWidthRst = 6'd16;
	localparam logic [GenW-1:0]      GenRst      = 32'h0000_1021;

endpackage

`default_nettype wire

FILE: hw/rtl/crc_generate_and_check_core.sv
// crc generate and check core: bit-serial crc with programmable polynomial
// depends on crc_gc_pkg and crc_generate_and_check_core_defines.svh
`default_nettype none

// One frame bit is taken per data transfer, msb first, and the remainder
// register (zero start, no reflection, no final xor) is updated in the same
// cycle, so a new bit is accepted every cycle while the data side is not
// stalled. In generate mode every information bit comes back as one result;
// after the last one the crc_width remainder bits follow as results, msb
// first, the final one marked last. While those crc bits drain from the
// shift register the data side is stalled; a generate frame of K information
// bits and W crc bits gives K + W results. In check mode the received crc
// bits give no result except a single verdict with the last of them. Results
// sit in one output register: a stall on the result side holds the data side
// only while that register is full.
// Any configuration write restarts the frame; write only when idle.
module crc_generate_and_check_core #(
	parameter int MAX_CRC_WIDTH = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write port
	input  wire logic                            cfg_write,
	input  wire logic [crc_gc_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [crc_gc_pkg::CfgDataW-1:0] cfg_data,
	// frame bit input
	input  wire logic                            data_valid,
	output      logic                            data_stall,
	input  wire logic                            data_bit,
	// result output
	output      logic                            result_valid,
	input  wire logic                            result_stall,
	output      logic                            out_bit,
	output      logic                            is_crc_bit,
	output      logic                            is_verdict,
	output      logic                            crc_ok,
	output      logic                            last
);

	`include "crc_generate_and_check_core_defines.svh"

	localparam int MaxW = MAX_CRC_WIDTH;
	localparam int WW   = $clog2(MAX_CRC_WIDTH + 1);
	localparam int PW   = crc_gc_pkg::BitPosW;

	localparam logic [crc_gc_pkg::CrcWidthW:0] MaxWCmp =
		(crc_gc_pkg::CrcWidthW+1)'(MAX_CRC_WIDTH);
	localparam logic [WW-1:0] MaxWw = WW'(MAX_CRC_WIDTH);

	// configuration registers
	logic                               mode_q;
	logic [crc_gc_pkg::InfoLenW-1:0]    info_len_q;
	logic [crc_gc_pkg::CrcWidthW-1:0]   crc_width_q;
	logic [crc_gc_pkg::GenW-1:0]        gen_q;

	// frame state
	logic [MaxW-1:0] rem_q;
	logic [PW-1:0]   bit_pos_q;
	logic            mismatch_q;

	// crc drain after the last information bit in generate mode
	logic            crc_pend_q;
	logic [WW-1:0]   crc_cnt_q;
	logic [MaxW-1:0] crc_sr_q;

	// output register
	logic result_valid_q;
	logic out_bit_q, is_crc_q, is_verdict_q, crc_ok_q, last_q;

	// effective widths and derived values
	logic [WW-1:0]                   w_eff;
	logic [WW-1:0]                   w_m1;
	logic [crc_gc_pkg::InfoLenW-1:0] k_eff;
	logic [PW-1:0]                   k_ext;
	logic [PW-1:0]                   w_ext;
	logic [MaxW-1:0]                 w_mask;
	logic [MaxW-1:0]                 gen_m;
	logic [MaxW-1:0]                 rem_top_sh;
	logic                            fb;
	logic [MaxW-1:0]                 rem_shl;
	logic [MaxW-1:0]                 rem_info;
	logic [PW-1:0]                   pos_inc;
	logic                            in_info;
	logic                            info_done;
	logic                            past_end;
	logic [PW-1:0]                   crc_i;
	logic [PW-1:0]                   exp_idx;
	logic [MaxW-1:0]                 rem_exp_sh;
	logic                            bit_differs;
	logic                            final_crc;
	logic [MaxW-1:0]                 crc_aligned;

	logic accept;
	logic out_load;
	logic res_produce;
	logic res_bit, res_crc, res_ver, res_ok, res_last;

	// handshake: hold off new bits while crc bits drain or the result is stuck
	assign data_stall = crc_pend_q || (result_valid_q && result_stall);
	assign accept     = data_valid && !data_stall;
	assign out_load   = !result_valid_q || !result_stall;

	// zero width reads as one, widths above the maximum saturate
	always_comb begin
		if (crc_width_q == '0) begin
			w_eff = WW'(1);
		end else if ({1'b0, crc_width_q} > MaxWCmp) begin
			w_eff = MaxWw;
		end else begin
			w_eff = WW'(crc_width_q);
		end
	end

	assign w_m1   = w_eff - WW'(1);
	assign k_eff  = (info_len_q == '0) ? crc_gc_pkg::InfoLenW'(1) : info_len_q;
	assign k_ext  = PW'(k_eff);
	assign w_ext  = PW'(w_eff);
	assign w_mask = ~({MaxW{1'b1}} << w_eff);
	assign gen_m  = MaxW'(gen_q) & w_mask;

	// lfsr step: shift left, fold in the generator when input and top bit differ
	assign rem_top_sh = rem_q >> w_m1;
	assign fb         = data_bit ^ rem_top_sh[0];
	assign rem_shl    = (rem_q << 1) & w_mask;
	assign rem_info   = fb ? (rem_shl ^ gen_m) : rem_shl;

	assign pos_inc   = bit_pos_q + PW'(1);
	assign in_info   = bit_pos_q < k_ext;
	assign info_done = pos_inc == k_ext;
	assign past_end  = bit_pos_q >= (k_ext + w_ext);

	// received crc bit i is compared with remainder bit w-1-i
	assign crc_i       = bit_pos_q - k_ext;
	assign exp_idx     = w_ext - PW'(1) - crc_i;
	assign rem_exp_sh  = rem_q >> exp_idx;
	assign bit_differs = rem_exp_sh[0] != data_bit;
	assign final_crc   = crc_i == (w_ext - PW'(1));

	// remainder left-aligned so the drain always takes the msb
	assign crc_aligned = rem_info << (MaxWw - w_eff);

	// next result
	always_comb begin
		res_produce = 1'b0;
		res_bit     = 1'b0;
		res_crc     = 1'b0;
		res_ver     = 1'b0;
		res_ok      = 1'b0;
		res_last    = 1'b0;
		if (crc_pend_q) begin
			res_produce = 1'b1;
			res_bit     = crc_sr_q[MaxW-1];
			res_crc     = 1'b1;
			res_last    = crc_cnt_q == WW'(1);
		end else if (accept) begin
			if (in_info) begin
				res_produce = 1'b1;
				res_bit     = data_bit;
			end else if (mode_q == crc_gc_pkg::MODE_CHECK && !past_end && final_crc) begin
				res_produce = 1'b1;
				res_ver     = 1'b1;
				res_ok      = !(mismatch_q || bit_differs);
				res_last    = 1'b1;
			end
		end
	end

	// configuration and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= crc_gc_pkg::MODE_GENERATE;
			info_len_q  <= crc_gc_pkg::InfoLenRst;
			crc_width_q <= crc_gc_pkg::CrcWidthRst;
			gen_q       <= crc_gc_pkg::GenRst;
			rem_q       <= '0;
			bit_pos_q   <= '0;
			mismatch_q  <= 1'b0;
			crc_pend_q  <= 1'b0;
			crc_cnt_q   <= '0;
		end else if (cfg_write) begin
			unique case (crc_gc_pkg::cfg_reg_t'(cfg_index))
				crc_gc_pkg::REG_MODE:      mode_q      <= cfg_data[0];
				crc_gc_pkg::REG_INFO_LEN:  info_len_q  <= cfg_data[crc_gc_pkg::InfoLenW-1:0];
				crc_gc_pkg::REG_CRC_WIDTH: crc_width_q <= cfg_data[crc_gc_pkg::CrcWidthW-1:0];
				crc_gc_pkg::REG_GENERATOR: gen_q       <= cfg_data[crc_gc_pkg::GenW-1:0];
				default: ;
			endcase
			// any write aborts the frame
			rem_q      <= '0;
			bit_pos_q  <= '0;
			mismatch_q <= 1'b0;
		end else begin
			if (crc_pend_q && out_load) begin
				crc_cnt_q <= crc_cnt_q - WW'(1);
				if (crc_cnt_q == WW'(1)) begin
					crc_pend_q <= 1'b0;
				end
			end
			if (accept) begin
				if (in_info) begin
					if (mode_q == crc_gc_pkg::MODE_GENERATE && info_done) begin
						// frame ends here, crc bits drain from the shift register
						rem_q      <= '0;
						bit_pos_q  <= '0;
						mismatch_q <= 1'b0;
						crc_pend_q <= 1'b1;
						crc_cnt_q  <= w_eff;
					end else begin
						rem_q     <= rem_info;
						bit_pos_q <= pos_inc;
					end
				end else if (mode_q == crc_gc_pkg::MODE_GENERATE || past_end) begin
					// position beyond the frame: start over
					rem_q      <= '0;
					bit_pos_q  <= '0;
					mismatch_q <= 1'b0;
				end else if (final_crc) begin
					rem_q      <= '0;
					bit_pos_q  <= '0;
					mismatch_q <= 1'b0;
				end else begin
					bit_pos_q  <= pos_inc;
					mismatch_q <= mismatch_q || bit_differs;
				end
			end
		end
	end

	// crc drain shift register
	always_ff @(posedge clk) begin
		if (accept && in_info && mode_q == crc_gc_pkg::MODE_GENERATE && info_done) begin
			crc_sr_q <= crc_aligned;
		end else if (crc_pend_q && out_load) begin
			crc_sr_q <= crc_sr_q << 1;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= res_produce;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load && res_produce) begin
			out_bit_q    <= res_bit;
			is_crc_q     <= res_crc;
			is_verdict_q <= res_ver;
			crc_ok_q     <= res_ok;
			last_q       <= res_last;
		end
	end

	assign result_valid = result_valid_q;
	assign out_bit      = out_bit_q;
	assign is_crc_bit   = is_crc_q;
	assign is_verdict   = is_verdict_q;
	assign crc_ok       = crc_ok_q;
	assign last         = last_q;

	// checks
	`CRC_GC_ASSERT_NOW(a_drain_stalls_input, crc_pend_q, data_stall, "input taken during crc drain")
	`CRC_GC_ASSERT_NOW(a_drain_count_live, crc_pend_q, crc_cnt_q != '0, "crc drain with zero count")
	`CRC_GC_ASSERT_NOW(a_verdict_shape, result_valid_q && is_verdict_q, last_q && !is_crc_q && !out_bit_q, "malformed verdict result")
	`CRC_GC_ASSERT_NEXT(a_last_crc_ends_drain, crc_pend_q && out_load && crc_cnt_q == WW'(1), !crc_pend_q && result_valid_q && last_q, "crc drain did not end on last bit")

endmodule

`default_nettype wire

FILE: verif/tb_crc_generate_and_check_core.sv
// self-checking testbench for crc_generate_and_check_core: random and directed frames
// in generate and check mode, results compared against an in-bench bit-serial crc predictor
// depends on crc_gc_pkg and the crc_generate_and_check_core rtl
`timescale 1ns / 100ps

module tb_crc_generate_and_check_core;

	// one result transfer as seen on the output port
	typedef struct packed {
		logic out_bit;
		logic is_crc_bit;
		logic is_verdict;
		logic crc_ok;
		logic last;
	} crc_result_t;

	// how the information bits of a stimulus frame are filled
	typedef enum int {
		FILL_RANDOM,
		FILL_ONES,
		FILL_ZEROS
	} fill_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_write;
	logic [crc_gc_pkg::CfgIdxW-1:0]  cfg_index;
	logic [crc_gc_pkg::CfgDataW-1:0] cfg_data;
	logic                            data_valid;
	logic                            data_stall;
	logic                            data_bit;
	logic                            result_valid;
	logic                            result_stall;
	logic                            out_bit;
	logic                            is_crc_bit;
	logic                            is_verdict;
	logic                            crc_ok;
	logic                            last;

	crc_generate_and_check_core #(
		.MAX_CRC_WIDTH(32)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.data_valid  (data_valid),
		.data_stall  (data_stall),
		.data_bit    (data_bit),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_bit     (out_bit),
		.is_crc_bit  (is_crc_bit),
		.is_verdict  (is_verdict),
		.crc_ok      (crc_ok),
		.last        (last)
	);

	// frame bits waiting for the driver, and results the block still owes us
	bit          pending_bits[$];
	crc_result_t awaited_results[$];

	int bits_queued = 0;   // bits pushed by the stimulus
	int bits_sent   = 0;   // bits put on the data port by the driver
	int bits_taken  = 0;   // data transfers seen by the monitor
	int err_count   = 0;

	// idle percentages of the current phase
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// predictor copy of the registers (reset values from the package)
	logic                             mode_copy     = crc_gc_pkg::MODE_GENERATE;
	logic [crc_gc_pkg::InfoLenW-1:0]  info_len_copy = crc_gc_pkg::InfoLenRst;
	logic [crc_gc_pkg::CrcWidthW-1:0] crc_w_copy    = crc_gc_pkg::CrcWidthRst;
	logic [crc_gc_pkg::GenW-1:0]      poly_copy     = crc_gc_pkg::GenRst;

	// predictor frame state
	logic [31:0] crc_reg   = '0;
	int          frame_pos = 0;
	logic        crc_miss  = 1'b0;

	// effective settings on the stimulus side, used to build whole frames
	logic        stim_mode = crc_gc_pkg::MODE_GENERATE;
	int          stim_k    = 64;
	int          stim_w    = 16;
	logic [31:0] stim_poly = 32'h0000_1021;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// generous fixed limit; a hung block ends the run here
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report(input string what);
		err_count++;
		$display("%0t: mismatch: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic got, input logic want);
		if (got !== want)
			report($sformatf("%s got %b want %b", name, got, want));
	endtask

	function automatic void await_result(input logic b, input logic c, input logic v,
	                                     input logic ok, input logic l);
		crc_result_t r;
		r = '{b, c, v, ok, l};
		awaited_results.insert(awaited_results.size(), r);
	endfunction

	function automatic void restart_crc_frame();
		crc_reg   = '0;
		frame_pos = 0;
		crc_miss  = 1'b0;
	endfunction

	// advance the predicted crc register by one accepted frame bit and queue
	// whatever results that bit causes
	task automatic step_crc_frame(input logic b);
		int          w;
		int          k;
		int          i;
		logic [31:0] msk;
		logic        fb;
		w   = (crc_w_copy == 0) ? 1 : ((crc_w_copy > 32) ? 32 : int'(crc_w_copy));
		k   = (info_len_copy == 0) ? 1 : int'(info_len_copy);
		msk = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
		if (frame_pos < k) begin
			// information bit: divide and pass it through
			fb      = b ^ crc_reg[w-1];
			crc_reg = (crc_reg << 1) & msk;
			if (fb)
				crc_reg = crc_reg ^ (poly_copy & msk);
			frame_pos++;
			await_result(b, 1'b0, 1'b0, 1'b0, 1'b0);
			if (frame_pos == k && mode_copy == crc_gc_pkg::MODE_GENERATE) begin
				// append the remainder msb first, final bit marked last
				for (i = 0; i < w; i++)
					await_result(crc_reg[w-1-i], 1'b1, 1'b0, 1'b0, (i == w - 1));
				restart_crc_frame();
			end
		end else if (mode_copy == crc_gc_pkg::MODE_GENERATE || frame_pos >= k + w) begin
			restart_crc_frame();
		end else begin
			// received crc bit: compare silently, verdict on the last one
			i = frame_pos - k;
			if (crc_reg[w-1-i] != b)
				crc_miss = 1'b1;
			frame_pos++;
			if (i + 1 == w) begin
				await_result(1'b0, 1'b0, 1'b1, !crc_miss, 1'b1);
				restart_crc_frame();
			end
		end
	endtask

	// monitor: register writes, data transfers and result transfers, all
	// sampled at the rising edge; prediction runs before the result check
	always @(posedge clk) begin : monitor
		crc_result_t want;
		if (arst_n) begin
			if (cfg_write) begin
				case (crc_gc_pkg::cfg_reg_t'(cfg_index))
					crc_gc_pkg::REG_MODE:      mode_copy     = cfg_data[0];
					crc_gc_pkg::REG_INFO_LEN:  info_len_copy = cfg_data[crc_gc_pkg::InfoLenW-1:0];
					crc_gc_pkg::REG_CRC_WIDTH: crc_w_copy    = cfg_data[crc_gc_pkg::CrcWidthW-1:0];
					crc_gc_pkg::REG_GENERATOR: poly_copy     = cfg_data[crc_gc_pkg::GenW-1:0];
					default: ;
				endcase
				// every write aborts the frame in progress
				restart_crc_frame();
			end
			if (data_valid && !data_stall) begin
				step_crc_frame(data_bit);
				bits_taken++;
			end
			if (result_valid && !result_stall) begin
				if (awaited_results.size() == 0) begin
					report("result transfer with nothing awaited");
				end else begin
					want = awaited_results.pop_front();
					check_field("out_bit", out_bit, want.out_bit);
					check_field("is_crc_bit", is_crc_bit, want.is_crc_bit);
					check_field("is_verdict", is_verdict, want.is_verdict);
					check_field("crc_ok", crc_ok, want.crc_ok);
					check_field("last", last, want.last);
				end
			end
		end
	end

	// driver: a new bit goes out only once the previous one has been taken,
	// so valid holds and the payload stays put through a stall
	always @(negedge clk) begin
		if (bits_taken == bits_sent) begin
			if (pending_bits.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				data_bit   <= pending_bits.pop_front();
				data_valid <= 1'b1;
				bits_sent++;
			end else begin
				data_valid <= 1'b0;
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic queue_bit(input bit b);
		pending_bits.insert(pending_bits.size(), b);
		bits_queued++;
	endtask

	// wait until every bit is taken and every result is in, then let the
	// silent check-mode bits and the output register settle
	task automatic wait_drained();
		while (bits_taken != bits_queued || awaited_results.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input crc_gc_pkg::cfg_reg_t idx, input logic [31:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	// program a full frame format; only done with the block idle
	task automatic set_frame_format(input logic m, input int k, input int w,
	                                input logic [31:0] g);
		wait_drained();
		write_reg(crc_gc_pkg::REG_MODE, {31'd0, m});
		write_reg(crc_gc_pkg::REG_INFO_LEN, k);
		write_reg(crc_gc_pkg::REG_CRC_WIDTH, w);
		write_reg(crc_gc_pkg::REG_GENERATOR, g);
		cfg_write <= 1'b0;
		stim_mode = m;
		stim_k    = (k == 0) ? 1 : k;
		stim_w    = (w == 0) ? 1 : ((w > 32) ? 32 : w);
		stim_poly = g;
	endtask

	// build one frame for the current format: information bits and, in check
	// mode, the matching crc (one bit flipped when corrupt is set); cut > 0
	// sends only that many leading bits
	task automatic send_frame(input fill_t fill, input bit corrupt, input int cut);
		bit          frame[$];
		logic [31:0] rem;
		logic [31:0] msk;
		bit          b;
		bit          fb;
		int          i;
		int          n;
		rem = '0;
		msk = (stim_w == 32) ? 32'hFFFF_FFFF : ((32'd1 << stim_w) - 32'd1);
		for (i = 0; i < stim_k; i++) begin
			case (fill)
				FILL_ONES:  b = 1'b1;
				FILL_ZEROS: b = 1'b0;
				default:    b = $urandom_range(1);
			endcase
			frame.insert(frame.size(), b);
			fb  = b ^ rem[stim_w-1];
			rem = (rem << 1) & msk;
			if (fb)
				rem = rem ^ (stim_poly & msk);
		end
		if (stim_mode == crc_gc_pkg::MODE_CHECK) begin
			if (corrupt)
				rem[$urandom_range(stim_w - 1)] ^= 1'b1;
			for (i = stim_w - 1; i >= 0; i--)
				frame.insert(frame.size(), rem[i]);
		end
		n = (cut > 0 && cut < frame.size()) ? cut : frame.size();
		for (i = 0; i < n; i++)
			queue_bit(frame[i]);
	endtask

	initial begin : stimulus
		int          ph;
		int          goal;
		int          nframes;
		int          f;
		int          k;
		int          w;
		int          cut;
		int          total;
		logic        m;
		logic [31:0] g;
		bit          bad;

		arst_n       <= 1'b0;
		cfg_write    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		data_valid   <= 1'b0;
		data_bit     <= 1'b0;
		result_stall <= 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: a few bits at the reset format, cut short by the next write
		queue_bit(1'b1);
		queue_bit(1'b0);
		queue_bit(1'b1);
		queue_bit(1'b1);

		// zero info length and zero crc width both act as one
		set_frame_format(crc_gc_pkg::MODE_GENERATE, 0, 0, 32'h0000_0001);
		send_frame(FILL_ONES, 1'b0, 0);
		send_frame(FILL_ZEROS, 1'b0, 0);

		// crc width past the maximum saturates, all-ones polynomial
		set_frame_format(crc_gc_pkg::MODE_GENERATE, 1, 63, 32'hFFFF_FFFF);
		send_frame(FILL_ONES, 1'b0, 0);
		send_frame(FILL_ZEROS, 1'b0, 0);

		// check mode: a good crc, then a corrupted one
		set_frame_format(crc_gc_pkg::MODE_CHECK, 2, 3, 32'h0000_0003);
		send_frame(FILL_RANDOM, 1'b0, 0);
		send_frame(FILL_ONES, 1'b1, 0);

		// check mode with minimal sizes and an all-zero polynomial
		set_frame_format(crc_gc_pkg::MODE_CHECK, 0, 0, 32'h0000_0000);
		send_frame(FILL_ONES, 1'b0, 0);
		send_frame(FILL_ZEROS, 1'b1, 0);

		// check frame stopped inside its crc bits, aborted by the next write
		set_frame_format(crc_gc_pkg::MODE_CHECK, 3, 32, 32'h04C1_1DB7);
		send_frame(FILL_RANDOM, 1'b0, 5);

		// random part: four idle phases, mostly whole frames of small size
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			goal = bits_queued + 100;
			while (bits_queued < goal) begin
				m = $urandom_range(1);
				if ($urandom_range(5) == 0) begin
					case ($urandom_range(4))
						0: w = 0;
						1: w = 1;
						2: w = 32;
						3: w = 33;
						default: w = 63;
					endcase
				end else begin
					w = $urandom_range(1, 32);
				end
				case ($urandom_range(7))
					0: g = 32'h0000_0000;
					1: g = 32'hFFFF_FFFF;
					default: g = $urandom;
				endcase
				if ($urandom_range(9) == 0) begin
					// huge info length: only a short head, then aborted
					k = ($urandom_range(1) != 0) ? 65535 : $urandom_range(32768, 65535);
					set_frame_format(m, k, w, g);
					send_frame(FILL_RANDOM, 1'b0, $urandom_range(1, 4));
				end else begin
					case ($urandom_range(9))
						0: k = 0;
						1: k = $urandom_range(21, 80);
						default: k = $urandom_range(1, 20);
					endcase
					set_frame_format(m, k, w, g);
					nframes = $urandom_range(1, 3);
					for (f = 0; f < nframes; f++) begin
						bad   = (stim_mode == crc_gc_pkg::MODE_CHECK) && ($urandom_range(3) == 0);
						total = stim_k + ((stim_mode == crc_gc_pkg::MODE_CHECK) ? stim_w : 0);
						// now and then a broken frame that stops early
						cut = (total > 1 && $urandom_range(7) == 0)
							? $urandom_range(1, total - 1) : 0;
						send_frame(FILL_RANDOM, bad, cut);
					end
				end
			end
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (err_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/crc_gc_pkg.sv
hw/rtl/crc_generate_and_check_core.sv
verif/tb_crc_generate_and_check_core.sv
